// File: design/fcpt_pkg.sv
// shared types, constants and the quarter-wave sine rom for the clarke/park transform core
// no dependencies; imported by fcpt_sincos and foc_clarke_park_transform_core
`timescale 1ns / 1ps

package fcpt_pkg;

   localparam int COMP_WIDTH  = 20;
   localparam int RES_WIDTH   = 21;
   localparam int ANGLE_WIDTH = 10;
   localparam int OP_WIDTH    = 2;
   localparam int COEF_WIDTH  = 16;
   localparam int TABLE_DEPTH = 256;
   localparam int IDX_WIDTH   = $clog2(TABLE_DEPTH);
   localparam int QUAD_WIDTH  = ANGLE_WIDTH - IDX_WIDTH;

   localparam int CLARKE_GAIN   = 2365;
   localparam int GAIN_WIDTH    = 13;
   localparam int PARK_SHIFT    = 12;
   localparam int IPARK_SHIFT   = 15;
   localparam int COEF_PRESHIFT = 3;

   localparam int PROD_WIDTH     = COMP_WIDTH + COEF_WIDTH;
   localparam int SUM_WIDTH      = PROD_WIDTH + 1;
   localparam int CLK_SUM_WIDTH  = COMP_WIDTH + 2;
   localparam int CLK_PROD_WIDTH = CLK_SUM_WIDTH + GAIN_WIDTH;

   typedef logic [OP_WIDTH-1:0]           op_type;
   typedef logic signed [COMP_WIDTH-1:0]  comp_type;
   typedef logic [ANGLE_WIDTH-1:0]        angle_type;
   typedef logic signed [RES_WIDTH-1:0]   res_type;
   typedef logic signed [COEF_WIDTH-1:0]  coef_type;
   typedef logic [TABLE_DEPTH-1:0][COEF_WIDTH-1:0] rom_type;

   localparam op_type OP_CLARKE = 2'd0;
   localparam op_type OP_PARK   = 2'd1;
   localparam op_type OP_IPARK  = 2'd2;

   localparam logic [63:0] PI_Q30 = 64'd3373259426;

   // restoring shift/subtract divide, only evaluated while building the rom
   function automatic logic [63:0] udiv64(logic [63:0] num, logic [63:0] den);
      logic [63:0] quo;
      logic [63:0] rem;
      quo = '0;
      rem = '0;
      for (int bit_pos = 63; bit_pos >= 0; bit_pos--) begin
         rem = {rem[62:0], num[bit_pos]};
         if (rem >= den) begin
            rem          = rem - den;
            quo[bit_pos] = 1'b1;
         end
      end
      return quo;
   endfunction

   // entry k = round(32768 * sin(k * pi / 512)), fixed-point taylor series
   function automatic rom_type build_sine_rom();
      rom_type     rom;
      logic [63:0] x;
      logic [63:0] x2;
      logic [63:0] sum;
      logic [63:0] term;
      logic [63:0] div;
      rom = '0;
      for (int n = 0; n < TABLE_DEPTH; n++) begin
         x    = (64'(n) * PI_Q30 + 64'd256) >> 9;
         x2   = (x * x) >> 30;
         sum  = x;
         term = x;
         for (int k = 1; k <= 8; k++) begin
            div  = 64'((2 * k) * (2 * k + 1));
            term = udiv64((term * x2) >> 30, div);
            if (k[0]) begin
               sum = sum - term;
            end else begin
               sum = sum + term;
            end
         end
         rom[n] = COEF_WIDTH'((sum * 64'd32768 + (64'd1 << 29)) >> 30);
      end
      return rom;
   endfunction

   localparam rom_type SINE_ROM = build_sine_rom();

endpackage

// File: design/foc_clarke_park_transform_core.sv
// clarke, park and inverse park transform core, fully pipelined
// depends on fcpt_pkg and fcpt_sincos
`timescale 1ns / 1ps

// usage
//   request channel: drive req_op, req_comp_a, req_comp_b, req_angle and pulse
//   start; a request is taken at every rising edge with start high and busy low.
//   busy is always low, so a request may be issued in every cycle.
//   response channel: rsp_valid is high for exactly one cycle per request, with
//   rsp_res_a / rsp_res_b holding the transform result in that cycle.
//   ops: clarke (a passes through, beta from a and b), park current (q12 math
//   on preshifted sin/cos), inverse park voltage (q15 math); the unused op code
//   returns zeros. the angle is ignored for clarke.
//   throughput: one request per cycle through the four-stage pipe
//   (input register, coefficient lookup, multiply, add/shift/result register).
//   responses come out in request order, one per request.
//   reset (synchronous, active high) empties the pipe; requests in flight are
//   dropped and no response strobe follows. the sine rom is constant.
//   the receiver cannot stall: each response is shown for one cycle only.

module foc_clarke_park_transform_core (
   input  logic                clock,
   input  logic                reset,
   input  logic                start,
   output logic                busy,
   input  fcpt_pkg::op_type    req_op,
   input  fcpt_pkg::comp_type  req_comp_a,
   input  fcpt_pkg::comp_type  req_comp_b,
   input  fcpt_pkg::angle_type req_angle,
   output logic                rsp_valid,
   output fcpt_pkg::res_type   rsp_res_a,
   output fcpt_pkg::res_type   rsp_res_b
);
   import fcpt_pkg::*;

   // stage 1: request register
   logic      s1_valid_ff, s1_valid_in;
   op_type    s1_op_ff;
   comp_type  s1_a_ff;
   comp_type  s1_b_ff;
   angle_type s1_angle_ff;

   // stage 2: coefficients
   logic      s2_valid_ff, s2_valid_in;
   op_type    s2_op_ff;
   comp_type  s2_a_ff;
   comp_type  s2_b_ff;
   coef_type  s2_sin_ff, s2_sin_in;
   coef_type  s2_cos_ff, s2_cos_in;

   // stage 3: products
   logic                               s3_valid_ff, s3_valid_in;
   op_type                             s3_op_ff;
   comp_type                           s3_a_ff;
   logic signed [PROD_WIDTH-1:0]       s3_ca_ff, s3_ca_in;
   logic signed [PROD_WIDTH-1:0]       s3_sb_ff, s3_sb_in;
   logic signed [PROD_WIDTH-1:0]       s3_sa_ff, s3_sa_in;
   logic signed [PROD_WIDTH-1:0]       s3_cb_ff, s3_cb_in;
   logic signed [CLK_PROD_WIDTH-1:0]   s3_clk_ff, s3_clk_in;

   // stage 4: result register
   logic    rsp_valid_ff, rsp_valid_in;
   res_type rsp_a_ff, rsp_a_in;
   res_type rsp_b_ff, rsp_b_in;

   coef_type                          lut_sin;
   coef_type                          lut_cos;
   logic signed [CLK_SUM_WIDTH-1:0]   clk_sum;
   logic signed [GAIN_WIDTH-1:0]      clk_gain;
   logic signed [SUM_WIDTH-1:0]       sum_a;
   logic signed [SUM_WIDTH-1:0]       sum_b;
   logic signed [SUM_WIDTH-1:0]       park_a;
   logic signed [SUM_WIDTH-1:0]       park_b;
   logic signed [SUM_WIDTH-1:0]       ipark_a;
   logic signed [SUM_WIDTH-1:0]       ipark_b;
   logic signed [CLK_PROD_WIDTH-1:0]  clk_beta;

   // the pipe never stalls, so a request is taken every cycle
   assign busy = 1'b0;

   // ---------------- stage 1: capture request ----------------
   assign s1_valid_in = start & ~busy;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s1_op_ff    <= req_op;
      s1_a_ff     <= req_comp_a;
      s1_b_ff     <= req_comp_b;
      s1_angle_ff <= req_angle;
   end

   // ---------------- stage 2: sin/cos lookup ----------------
   fcpt_sincos u_sincos (
      .angle   (s1_angle_ff),
      .sin_q15 (lut_sin),
      .cos_q15 (lut_cos)
   );

   // park current works on coefficients brought down to q12
   always_comb begin
      s2_valid_in = s1_valid_ff;
      if (s1_op_ff == OP_PARK) begin
         s2_sin_in = lut_sin >>> COEF_PRESHIFT;
         s2_cos_in = lut_cos >>> COEF_PRESHIFT;
      end else begin
         s2_sin_in = lut_sin;
         s2_cos_in = lut_cos;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s2_valid_ff <= 1'b0;
      end else begin
         s2_valid_ff <= s2_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s2_op_ff  <= s1_op_ff;
      s2_a_ff   <= s1_a_ff;
      s2_b_ff   <= s1_b_ff;
      s2_sin_ff <= s2_sin_in;
      s2_cos_ff <= s2_cos_in;
   end

   // ---------------- stage 3: multipliers ----------------
   // clarke: (a + 2b) * gain, the 2b term is a plain left shift
   assign clk_gain = GAIN_WIDTH'(CLARKE_GAIN);
   assign clk_sum  = CLK_SUM_WIDTH'(s2_a_ff) + (CLK_SUM_WIDTH'(s2_b_ff) <<< 1);

   always_comb begin
      s3_valid_in = s2_valid_ff;
      s3_ca_in    = PROD_WIDTH'(s2_cos_ff) * PROD_WIDTH'(s2_a_ff);
      s3_sb_in    = PROD_WIDTH'(s2_sin_ff) * PROD_WIDTH'(s2_b_ff);
      s3_sa_in    = PROD_WIDTH'(s2_sin_ff) * PROD_WIDTH'(s2_a_ff);
      s3_cb_in    = PROD_WIDTH'(s2_cos_ff) * PROD_WIDTH'(s2_b_ff);
      s3_clk_in   = CLK_PROD_WIDTH'(clk_sum) * CLK_PROD_WIDTH'(clk_gain);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s3_valid_ff <= 1'b0;
      end else begin
         s3_valid_ff <= s3_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      s3_op_ff  <= s2_op_ff;
      s3_a_ff   <= s2_a_ff;
      s3_ca_ff  <= s3_ca_in;
      s3_sb_ff  <= s3_sb_in;
      s3_sa_ff  <= s3_sa_in;
      s3_cb_ff  <= s3_cb_in;
      s3_clk_ff <= s3_clk_in;
   end

   // ---------------- stage 4: sums, shifts, op select ----------------
   assign sum_a    = SUM_WIDTH'(s3_ca_ff) + SUM_WIDTH'(s3_sb_ff);
   assign sum_b    = SUM_WIDTH'(s3_sa_ff) - SUM_WIDTH'(s3_cb_ff);
   assign park_a   = sum_a >>> PARK_SHIFT;
   assign park_b   = sum_b >>> PARK_SHIFT;
   assign ipark_a  = sum_a >>> IPARK_SHIFT;
   assign ipark_b  = sum_b >>> IPARK_SHIFT;
   assign clk_beta = s3_clk_ff >>> PARK_SHIFT;

   // results are the low bits of the exact value
   always_comb begin
      rsp_valid_in = s3_valid_ff;
      unique case (s3_op_ff)
         OP_CLARKE: begin
            rsp_a_in = RES_WIDTH'(s3_a_ff);
            rsp_b_in = res_type'(clk_beta[RES_WIDTH-1:0]);
         end
         OP_PARK: begin
            rsp_a_in = res_type'(park_a[RES_WIDTH-1:0]);
            rsp_b_in = res_type'(park_b[RES_WIDTH-1:0]);
         end
         OP_IPARK: begin
            rsp_a_in = res_type'(ipark_a[RES_WIDTH-1:0]);
            rsp_b_in = res_type'(ipark_b[RES_WIDTH-1:0]);
         end
         default: begin
            // unused op code answers with zeros
            rsp_a_in = '0;
            rsp_b_in = '0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_a_ff <= rsp_a_in;
      rsp_b_ff <= rsp_b_in;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_res_a = rsp_a_ff;
   assign rsp_res_b = rsp_b_ff;

endmodule

// File: design/fcpt_sincos.sv
// quadrant-mirrored sin/cos lookup from the quarter-wave rom
// depends on fcpt_pkg
`timescale 1ns / 1ps

module fcpt_sincos (
   input  fcpt_pkg::angle_type angle,
   output fcpt_pkg::coef_type  sin_q15,
   output fcpt_pkg::coef_type  cos_q15
);
   import fcpt_pkg::*;

   logic [IDX_WIDTH-1:0]  idx_i;
   logic [IDX_WIDTH-1:0]  idx_j;
   logic [QUAD_WIDTH-1:0] quad;
   coef_type              rom_i;
   coef_type              rom_j;

   assign idx_i = angle[IDX_WIDTH-1:0];
   assign idx_j = ~idx_i;   // mirrored index
   assign quad  = angle[ANGLE_WIDTH-1:IDX_WIDTH];
   assign rom_i = coef_type'(SINE_ROM[idx_i]);
   assign rom_j = coef_type'(SINE_ROM[idx_j]);

   always_comb begin
      unique case (quad)
         2'd0: begin
            sin_q15 = rom_i;
            cos_q15 = rom_j;
         end
         2'd1: begin
            sin_q15 = rom_j;
            cos_q15 = -rom_i;
         end
         2'd2: begin
            sin_q15 = -rom_i;
            cos_q15 = -rom_j;
         end
         default: begin
            sin_q15 = -rom_j;
            cos_q15 = rom_i;
         end
      endcase
   end

endmodule
